// ===== rtl/core/fbfl_pkg.sv =====
package fbfl_pkg;

    localparam int NUM_BLOCKS = 256;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [1:0]       status_t;

    localparam logic    CMD_ALLOC = 1'b0;
    localparam logic    CMD_FREE  = 1'b1;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    localparam cnt_t COUNT_MAX = CNT_W'(NUM_BLOCKS);

    // Link memory access, one per cycle: a read or a write, or a clear
    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rd_en;
        idx_t addr;
        idx_t wr_link;
        logic wr_last;
    } mem_cmd_t;

    typedef struct packed {
        idx_t link;
        logic last;
    } mem_rsp_t;

    // Zero acts as one, anything above the pool size as the pool size
    function automatic cnt_t eff_count(cnt_t v);
        cnt_t r;
        r = v;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > COUNT_MAX)
        begin
            r = COUNT_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/fbfl_if.sv =====
interface fbfl_req_if;
    logic             valid;
    logic             ready;
    logic             cmd;
    fbfl_pkg::idx_t   block_index;

    modport source (output valid, output cmd, output block_index, input ready);
    modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

interface fbfl_rsp_if;
    logic              valid;
    logic              ready;
    fbfl_pkg::status_t status;
    fbfl_pkg::idx_t    granted_index;
    fbfl_pkg::cnt_t    free_blocks;

    modport source (output valid, output status, output granted_index,
                    output free_blocks, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input free_blocks, output ready);
endinterface

interface fbfl_cfg_if;
    logic           valid;
    logic           ready;
    fbfl_pkg::cnt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fbfl_link_mem.sv =====
module fbfl_link_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  fbfl_pkg::mem_cmd_t cmd,
    output fbfl_pkg::mem_rsp_t rsp
);
    import fbfl_pkg::*;

    mem_rsp_t               mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]  written_reg;
    mem_rsp_t               rd_data_reg;
    logic                   rd_hit_reg;
    idx_t                   rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr] <= '{link: cmd.wr_link, last: cmd.wr_last};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.addr];
            rd_addr_reg <= cmd.addr;
        end
    end

    // Entries not yet written since the last rebuild read as the descending chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                written_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                written_reg[cmd.addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_hit_reg <= written_reg[cmd.addr];
            end
        end
    end

    always_comb
    begin
        if (rd_hit_reg)
        begin
            rsp = rd_data_reg;
        end
        else
        begin
            rsp.link = rd_addr_reg - IDX_W'(1);
            rsp.last = (rd_addr_reg == '0);
        end
    end

endmodule

// ===== rtl/core/fbfl_ctrl.sv =====
module fbfl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    fbfl_req_if.sink           req,
    fbfl_rsp_if.source         rsp,
    fbfl_cfg_if.sink           cfg,
    output fbfl_pkg::mem_cmd_t mem_cmd,
    input  fbfl_pkg::mem_rsp_t mem_rsp
);
    import fbfl_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic    state_reg,     state_next;
    cnt_t    count_reg,     count_next;
    idx_t    head_reg,      head_next;
    logic    empty_reg,     empty_next;
    cnt_t    used_reg,      used_next;
    logic    out_valid_reg, out_valid_next;
    status_t status_reg,    status_next;
    idx_t    granted_reg,   granted_next;
    cnt_t    free_reg,      free_next;

    logic    req_fire;
    logic    cfg_fire;
    cnt_t    new_count;

    // A pending config write takes the cycle, so requests wait
    assign req.ready = (state_reg == ST_IDLE) && !cfg.valid && (!out_valid_reg || rsp.ready);
    assign cfg.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign new_count = eff_count(cfg.data);

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.granted_index = granted_reg;
    assign rsp.free_blocks   = free_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        granted_next   = granted_reg;
        free_next      = free_reg;
        mem_cmd        = '{clear: 1'b0, wr_en: 1'b0, rd_en: 1'b0,
                           addr: head_reg, wr_link: head_reg, wr_last: empty_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    count_next    = new_count;
                    head_next     = IDX_W'(new_count - CNT_W'(1));
                    empty_next    = 1'b0;
                    used_next     = '0;
                    mem_cmd.clear = 1'b1;
                end
                else if (req_fire)
                begin
                    if (req.cmd == CMD_ALLOC)
                    begin
                        if (empty_reg || ({1'b0, head_reg} >= count_reg))
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_EMPTY;
                            granted_next   = '0;
                            free_next      = count_reg - used_reg;
                        end
                        else
                        begin
                            // Fetch the link of the head, finish next cycle
                            mem_cmd.rd_en = 1'b1;
                            state_next    = ST_POP;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        granted_next   = '0;
                        if ({1'b0, req.block_index} >= count_reg)
                        begin
                            status_next = STATUS_RANGE;
                            free_next   = count_reg - used_reg;
                        end
                        else
                        begin
                            mem_cmd.wr_en = 1'b1;
                            mem_cmd.addr  = req.block_index;
                            head_next     = req.block_index;
                            empty_next    = 1'b0;
                            if (used_reg != '0)
                            begin
                                used_next = used_reg - CNT_W'(1);
                            end
                            status_next = STATUS_OK;
                            free_next   = count_reg - used_next;
                        end
                    end
                end
            end
            ST_POP:
            begin
                if (mem_rsp.last)
                begin
                    empty_next = 1'b1;
                end
                else
                begin
                    head_next = mem_rsp.link;
                end
                if (used_reg < count_reg)
                begin
                    used_next = used_reg + CNT_W'(1);
                end
                out_valid_next = 1'b1;
                status_next    = STATUS_OK;
                granted_next   = head_reg;
                free_next      = count_reg - used_next;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_MAX;
            head_reg      <= IDX_W'(COUNT_MAX - CNT_W'(1));
            empty_reg     <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
        free_reg    <= free_next;
    end

`ifndef SYNTHESIS
    // The result slot is empty while a pop waits on the link memory
    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> !out_valid_reg)
        else $error("result pending during pop");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= count_reg)
        else $error("used count above block count");

    a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        !empty_reg |-> ({1'b0, head_reg} < count_reg))
        else $error("head outside pool");

    a_pop_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !cfg_fire && (req.cmd == CMD_ALLOC) && !empty_reg)
        |=> (state_reg == ST_POP))
        else $error("allocate did not start a pop");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> (out_valid_reg && (status_reg == STATUS_OK)))
        else $error("pop gave no grant");
`endif

endmodule

// ===== rtl/core/fixed_block_free_list_allocator.sv =====
// Allocate: the link memory read is registered, then the result is registered from the pop state.
// Free, failed allocate, rejected free: result registered in the cycle after the request is taken.
// One request at a time: an allocate holds off further requests while its pop is pending.
// Reset and a block_count write rebuild the free list at once: per-entry written
// bits clear, and unwritten entries read as the descending chain. No clearing pass.
module fixed_block_free_list_allocator (
    input  logic       clk,
    input  logic       rst_n,
    fbfl_req_if.sink   req,
    fbfl_rsp_if.source rsp,
    fbfl_cfg_if.sink   cfg
);
    import fbfl_pkg::*;

    mem_cmd_t mem_cmd;
    mem_rsp_t mem_rsp;

    fbfl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .cfg     (cfg),
        .mem_cmd (mem_cmd),
        .mem_rsp (mem_rsp)
    );

    fbfl_link_mem u_link_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .rsp   (mem_rsp)
    );

endmodule
